FILE: rtl/core/dwc_pkg.sv
// Shared types and codes of the differential unique-word correlator.
package dwc_pkg;

    localparam int SMP_W  = 16;
    localparam int PROD_W = 33;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int DIV_W  = 31;
    localparam int QUO_W  = 16;

    // Action codes of an input word
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic REG_SPS = 1'b0;
    localparam logic REG_UW  = 1'b1;

    typedef struct packed {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
    } cplx_t;

    typedef struct packed {
        cplx_t             val;
        logic [SMP_W-1:0]  mag;
    } entry_t;

endpackage

FILE: rtl/core/dwc_ifs.sv
// Valid/ready channel interfaces for sample words and result words.
interface dwc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [7:0]         ref_index;
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;

    modport source (output valid, action, ref_index, sample_i, sample_q, input ready);
    modport sink   (input valid, action, ref_index, sample_i, sample_q, output ready);
endinterface

interface dwc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] metric;
    logic        zero_energy;

    modport source (output valid, metric, zero_energy, input ready);
    modport sink   (input valid, metric, zero_energy, output ready);
endinterface

FILE: rtl/core/differential_uw_correlator_unit.sv
// Differential unique-word correlator: sequencer, stores and shared arithmetic.
// Load word: stored on acceptance; with a reference tap a 32-step root of the tap follows.
// Data word: a 32-step root of the new difference, then one tap per cycle through the shared
// complex multiplier for L taps, scaling of the sums, a second 32-step root pass and a
// 16-step divide. Clear and warm-up words start no work. One word is in work at a time.
// Reset (rst_n, async) clears control, registers, lag line and window; the reference
// store holds no reset value and must be loaded before use.
module differential_uw_correlator_unit #(
    parameter int MAX_UW_SAMPLES = 256,
    parameter int MAX_LAG        = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    dwc_in_if.sink      samples,
    dwc_out_if.source   results,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [5:0]  wr_data
);

    localparam int AW     = $clog2(MAX_UW_SAMPLES);
    localparam int LEN_W  = AW + 1;
    localparam int KW     = AW + 8;
    localparam int LW     = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
    localparam int SEEN_W = $clog2(MAX_LAG + 1);
    localparam int ACC_W  = 34 + AW;
    localparam int DEN_W  = 32 + AW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LD_RD  = 4'd1;
    localparam logic [3:0] S_LD_MUL = 4'd2;
    localparam logic [3:0] S_LD_SQ  = 4'd3;
    localparam logic [3:0] S_LD_MAG = 4'd4;
    localparam logic [3:0] S_D_MUL  = 4'd5;
    localparam logic [3:0] S_D_SQ   = 4'd6;
    localparam logic [3:0] S_D_MAG  = 4'd7;
    localparam logic [3:0] S_MAC    = 4'd8;
    localparam logic [3:0] S_ABS    = 4'd9;
    localparam logic [3:0] S_NORM   = 4'd10;
    localparam logic [3:0] S_SQ1    = 4'd11;
    localparam logic [3:0] S_SQ2    = 4'd12;
    localparam logic [3:0] S_MSQRT  = 4'd13;
    localparam logic [3:0] S_DIV    = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    // Round to Q1.15 and saturate
    function automatic logic signed [15:0] rnd_sat(input logic signed [32:0] p);
        logic signed [33:0] s;
        logic signed [18:0] q;
        s = {p[32], p} + 34'sd16384;
        q = s[33:15];
        if (q > 19'sd32767)
            return 16'sh7fff;
        else if (q < -19'sd32768)
            return 16'sh8000;
        else
            return q[15:0];
    endfunction

    logic [3:0]            state_reg;
    logic [3:0]            sps_reg;
    logic [5:0]            uw_reg;
    logic [3:0]            sps_eff;
    logic [5:0]            u_eff;
    logic [9:0]            len_raw;
    logic [LEN_W-1:0]      len_eff;

    dwc_pkg::cplx_t        lag_reg [MAX_LAG];
    logic [SEEN_W-1:0]     seen_reg;
    logic [LW-1:0]         lag_idx;
    logic                  warm;

    dwc_pkg::cplx_t        in_smp;
    dwc_pkg::cplx_t        x_reg;
    dwc_pkg::cplx_t        older_reg;
    dwc_pkg::cplx_t        d_reg;
    dwc_pkg::cplx_t        tap_reg;
    dwc_pkg::cplx_t        prod_rnd;
    logic [KW-1:0]         k_ext;
    logic [AW-1:0]         k_idx;
    logic [AW-1:0]         j_reg;
    logic                  acc_in;
    logic                  clr_hit;

    dwc_pkg::cplx_t        ref_mem [MAX_UW_SAMPLES];
    dwc_pkg::entry_t       tap_mem [MAX_UW_SAMPLES];
    dwc_pkg::entry_t       win_mem [MAX_UW_SAMPLES];
    logic                  win_full_reg;
    dwc_pkg::cplx_t        rs_rd;
    dwc_pkg::entry_t       tap_rd;
    dwc_pkg::entry_t       win_rd;
    logic                  wv_rd;

    logic [AW-1:0]         wp_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      t_reg;
    logic [AW-1:0]         slot;
    logic                  rd_vld_reg;
    logic                  mul_vld_reg;

    logic                  cm_conj;
    dwc_pkg::cplx_t        cm_a;
    dwc_pkg::cplx_t        cm_b;
    logic [15:0]           cm_mag_a;
    logic [15:0]           cm_mag_b;
    logic signed [32:0]    prod_re;
    logic signed [32:0]    prod_im;
    logic [31:0]           mag_prod;

    logic signed [ACC_W-1:0] nre_reg;
    logic signed [ACC_W-1:0] nim_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [ACC_W-1:0]      ar_reg;
    logic [ACC_W-1:0]      ai_reg;
    logic [ACC_W-1:0]      dn_reg;
    logic [30:0]           sq_op;
    logic [61:0]           sq_prod;
    logic [63:0]           sq_reg;

    logic                  go_reg;
    logic [63:0]           rad;
    logic                  sq_done;
    logic [31:0]           root;
    logic                  div_start;
    logic                  div_done;
    logic [15:0]           quo;

    logic [15:0]           res_metric_reg;
    logic                  res_zero_reg;
    logic                  out_vld_reg;
    logic [15:0]           out_metric_reg;
    logic                  out_zero_reg;

    // Effective lag and window length from the registers
    always_comb
    begin
        sps_eff = sps_reg;
        if (sps_reg == 4'd0)
            sps_eff = 4'd1;
        else if (32'(sps_reg) > MAX_LAG)
            sps_eff = 4'(MAX_LAG);
        u_eff   = (uw_reg < 6'd2) ? 6'd2 : uw_reg;
        len_raw = 10'(u_eff - 6'd1) * 10'(sps_eff);
        len_eff = (32'(len_raw) > MAX_UW_SAMPLES) ? LEN_W'(MAX_UW_SAMPLES)
                                                  : LEN_W'(len_raw);
    end

    assign in_smp    = '{re: samples.sample_i, im: samples.sample_q};
    assign acc_in    = samples.valid && samples.ready;
    assign clr_hit   = acc_in && (samples.action == dwc_pkg::ACT_CLEAR);
    assign k_ext     = KW'(samples.ref_index);
    assign k_idx     = k_ext[AW-1:0];
    assign lag_idx   = LW'(sps_eff - 4'd1);
    assign warm      = 8'(seen_reg) >= 8'(sps_eff);
    assign prod_rnd  = '{re: rnd_sat(prod_re), im: rnd_sat(prod_im)};
    assign slot      = wp_reg - len_reg[AW-1:0] + t_reg[AW-1:0];
    assign samples.ready = (state_reg == S_IDLE);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sps_reg <= 4'd1;
            uw_reg  <= 6'd2;
        end
        else if (wr_en)
        begin
            case (wr_index)
                dwc_pkg::REG_SPS: sps_reg <= wr_data[3:0];
                dwc_pkg::REG_UW:  uw_reg  <= wr_data;
                default:          sps_reg <= sps_reg;
            endcase
        end
    end

    // Lag line and sample count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LAG; i++)
                lag_reg[i] <= '0;
            seen_reg <= '0;
        end
        else if (clr_hit)
        begin
            for (int i = 0; i < MAX_LAG; i++)
                lag_reg[i] <= '0;
            seen_reg <= '0;
        end
        else if (acc_in && samples.action == dwc_pkg::ACT_DATA)
        begin
            for (int i = MAX_LAG - 1; i > 0; i--)
                lag_reg[i] <= lag_reg[i-1];
            lag_reg[0] <= in_smp;
            if (32'(seen_reg) < MAX_LAG)
                seen_reg <= seen_reg + SEEN_W'(1);
        end
    end

    // Reference sample store
    always_ff @(posedge clk)
    begin
        if (acc_in && samples.action == dwc_pkg::ACT_LOAD)
            ref_mem[k_idx] <= in_smp;
        rs_rd <= ref_mem[j_reg];
    end

    // Reference tap store
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LD_MAG && sq_done)
            tap_mem[j_reg] <= '{val: tap_reg, mag: root[15:0]};
        tap_rd <= tap_mem[t_reg[AW-1:0]];
    end

    // Differential window store; slots not written since a clear read as zero
    always_ff @(posedge clk)
    begin
        if (state_reg == S_D_MAG && sq_done)
            win_mem[wp_reg] <= '{val: d_reg, mag: root[15:0]};
        win_rd <= win_mem[slot];
        wv_rd  <= win_full_reg || (slot < wp_reg);
    end

    // Window fill flag and write pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_full_reg <= 1'b0;
            wp_reg       <= '0;
        end
        else if (clr_hit)
        begin
            win_full_reg <= 1'b0;
            wp_reg       <= '0;
        end
        else if (state_reg == S_D_MAG && sq_done)
        begin
            if (wp_reg == AW'(MAX_UW_SAMPLES - 1))
                win_full_reg <= 1'b1;
            wp_reg <= wp_reg + AW'(1);
        end
    end

    // Select operands of the shared multiplier
    always_comb
    begin
        cm_conj  = 1'b1;
        cm_a     = x_reg;
        cm_b     = older_reg;
        cm_mag_a = tap_rd.mag;
        cm_mag_b = wv_rd ? win_rd.mag : 16'd0;
        case (state_reg)
            S_LD_MUL:
            begin
                cm_b = rs_rd;
            end
            S_LD_SQ, S_D_SQ:
            begin
                cm_a = prod_rnd;
                cm_b = prod_rnd;
            end
            S_MAC:
            begin
                cm_conj = 1'b0;
                cm_a    = tap_rd.val;
                cm_b    = wv_rd ? win_rd.val : '0;
            end
            default:
            begin
                cm_conj = 1'b1;
            end
        endcase
    end

    dwc_cmul u_cmul (
        .clk      (clk),
        .conj     (cm_conj),
        .a        (cm_a),
        .b        (cm_b),
        .mag_a    (cm_mag_a),
        .mag_b    (cm_mag_b),
        .prod_re  (prod_re),
        .prod_im  (prod_im),
        .mag_prod (mag_prod)
    );

    assign rad = (state_reg == S_MSQRT) ? sq_reg : 64'($unsigned(prod_re));

    dwc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg),
        .radicand (rad),
        .done     (sq_done),
        .root     (root)
    );

    assign div_start = (state_reg == S_MSQRT) && sq_done && (root < {1'b0, dn_reg[30:0]});

    dwc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (root[30:0]),
        .den   (dn_reg[30:0]),
        .done  (div_done),
        .quo   (quo)
    );

    assign sq_op   = (state_reg == S_SQ1) ? ar_reg[30:0] : ai_reg[30:0];
    assign sq_prod = sq_op * sq_op;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            go_reg      <= 1'b0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            t_reg       <= '0;
            len_reg     <= '0;
        end
        else
        begin
            go_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (acc_in && samples.action == dwc_pkg::ACT_LOAD
                        && 32'(k_idx) >= 32'(sps_eff))
                        state_reg <= S_LD_RD;
                    else if (acc_in && samples.action == dwc_pkg::ACT_DATA && warm)
                        state_reg <= S_D_MUL;
                end
                S_LD_RD:  state_reg <= S_LD_MUL;
                S_LD_MUL: state_reg <= S_LD_SQ;
                S_LD_SQ:
                begin
                    go_reg    <= 1'b1;
                    state_reg <= S_LD_MAG;
                end
                S_LD_MAG:
                begin
                    if (sq_done)
                        state_reg <= S_IDLE;
                end
                S_D_MUL:  state_reg <= S_D_SQ;
                S_D_SQ:
                begin
                    go_reg    <= 1'b1;
                    state_reg <= S_D_MAG;
                end
                S_D_MAG:
                begin
                    if (sq_done)
                    begin
                        len_reg     <= len_eff;
                        t_reg       <= '0;
                        rd_vld_reg  <= 1'b0;
                        mul_vld_reg <= 1'b0;
                        state_reg   <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    rd_vld_reg  <= (t_reg < len_reg);
                    mul_vld_reg <= rd_vld_reg;
                    if (t_reg < len_reg)
                        t_reg <= t_reg + LEN_W'(1);
                    else if (!rd_vld_reg && !mul_vld_reg)
                        state_reg <= S_ABS;
                end
                S_ABS:
                begin
                    if (den_reg == '0)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    if (!(|ar_reg[ACC_W-1:31]) && !(|ai_reg[ACC_W-1:31])
                        && !(|dn_reg[ACC_W-1:31]))
                        state_reg <= S_SQ1;
                end
                S_SQ1:    state_reg <= S_SQ2;
                S_SQ2:
                begin
                    go_reg    <= 1'b1;
                    state_reg <= S_MSQRT;
                end
                S_MSQRT:
                begin
                    if (sq_done)
                        state_reg <= div_start ? S_DIV : S_DONE;
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_vld_reg || results.ready)
                        state_reg <= S_IDLE;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            x_reg     <= in_smp;
            older_reg <= lag_reg[lag_idx];
            j_reg     <= k_idx - AW'(sps_eff);
        end
        if (state_reg == S_LD_SQ)
            tap_reg <= prod_rnd;
        if (state_reg == S_D_SQ)
            d_reg <= prod_rnd;
        if (state_reg == S_D_MAG)
        begin
            nre_reg <= '0;
            nim_reg <= '0;
            den_reg <= '0;
        end
        else if (state_reg == S_MAC && mul_vld_reg)
        begin
            nre_reg <= nre_reg + ACC_W'(prod_re);
            nim_reg <= nim_reg + ACC_W'(prod_im);
            den_reg <= den_reg + DEN_W'(mag_prod);
        end
        case (state_reg)
            S_ABS:
            begin
                ar_reg <= nre_reg[ACC_W-1] ? ACC_W'(-nre_reg) : ACC_W'(nre_reg);
                ai_reg <= nim_reg[ACC_W-1] ? ACC_W'(-nim_reg) : ACC_W'(nim_reg);
                dn_reg <= ACC_W'(den_reg);
                res_metric_reg <= 16'd0;
                res_zero_reg   <= (den_reg == '0);
            end
            S_NORM:
            begin
                if ((|ar_reg[ACC_W-1:31]) || (|ai_reg[ACC_W-1:31])
                    || (|dn_reg[ACC_W-1:31]))
                begin
                    ar_reg <= ar_reg >> 1;
                    ai_reg <= ai_reg >> 1;
                    dn_reg <= dn_reg >> 1;
                end
            end
            S_SQ1:   sq_reg <= 64'(sq_prod);
            S_SQ2:   sq_reg <= sq_reg + 64'(sq_prod);
            S_MSQRT:
            begin
                if (sq_done && !div_start)
                    res_metric_reg <= 16'hffff;
            end
            S_DIV:
            begin
                if (div_done)
                    res_metric_reg <= quo;
            end
            default:
            begin
                sq_reg <= sq_reg;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (state_reg == S_DONE && (!out_vld_reg || results.ready))
            out_vld_reg <= 1'b1;
        else if (results.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_vld_reg || results.ready))
        begin
            out_metric_reg <= res_metric_reg;
            out_zero_reg   <= res_zero_reg;
        end
    end

    assign results.valid       = out_vld_reg;
    assign results.metric      = out_metric_reg;
    assign results.zero_energy = out_zero_reg;

    // A new result word only follows the final sequencer step
    ap_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(state_reg) == S_DONE)
        else $error("result word raised outside the final step");

    // The root unit finishes only while a step waits on it
    ap_root_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_LD_MAG || state_reg == S_D_MAG
                     || state_reg == S_MSQRT))
        else $error("root unit finished with no step waiting");

    // The window pointer moves only on a window write or a clear
    ap_wp_move: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg != $past(wp_reg)) |-> ($past(state_reg) == S_D_MAG || $past(clr_hit)))
        else $error("window pointer moved without a write");

    // The divider is started only for a fraction below one
    ap_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (dn_reg[ACC_W-1:31] == '0) && (dn_reg[30:0] != '0))
        else $error("divider started outside its range");

endmodule

FILE: rtl/core/dwc_cmul.sv
// Shared complex multiplier with magnitude product, one registered stage.
module dwc_cmul
(
    input  logic                               clk,
    input  logic                               conj,
    input  dwc_pkg::cplx_t                     a,
    input  dwc_pkg::cplx_t                     b,
    input  logic [dwc_pkg::SMP_W-1:0]          mag_a,
    input  logic [dwc_pkg::SMP_W-1:0]          mag_b,
    output logic signed [dwc_pkg::PROD_W-1:0]  prod_re,
    output logic signed [dwc_pkg::PROD_W-1:0]  prod_im,
    output logic [2*dwc_pkg::SMP_W-1:0]        mag_prod
);

    logic signed [31:0] p_rr;
    logic signed [31:0] p_ii;
    logic signed [31:0] p_ir;
    logic signed [31:0] p_ri;
    logic signed [32:0] x_rr;
    logic signed [32:0] x_ii;
    logic signed [32:0] x_ir;
    logic signed [32:0] x_ri;

    // Form the four partial products
    assign p_rr = a.re * b.re;
    assign p_ii = a.im * b.im;
    assign p_ir = a.im * b.re;
    assign p_ri = a.re * b.im;
    assign x_rr = {p_rr[31], p_rr};
    assign x_ii = {p_ii[31], p_ii};
    assign x_ir = {p_ir[31], p_ir};
    assign x_ri = {p_ri[31], p_ri};

    // Combine as a*conj(b) or a*b and register
    always_ff @(posedge clk)
    begin
        if (conj)
        begin
            prod_re <= x_rr + x_ii;
            prod_im <= x_ir - x_ri;
        end
        else
        begin
            prod_re <= x_rr - x_ii;
            prod_im <= x_ri + x_ir;
        end
        mag_prod <= mag_a * mag_b;
    end

endmodule

FILE: rtl/core/dwc_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module dwc_isqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [dwc_pkg::RAD_W-1:0]    radicand,
    output logic                         done,
    output logic [dwc_pkg::ROOT_W-1:0]   root
);

    logic [dwc_pkg::RAD_W-1:0] v_reg;
    logic [dwc_pkg::RAD_W-1:0] r_reg;
    logic [dwc_pkg::RAD_W-1:0] pw_reg;
    logic [dwc_pkg::RAD_W-1:0] trial;
    logic [4:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    assign trial = r_reg + pw_reg;

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Try one root bit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg  <= radicand;
            r_reg  <= '0;
            pw_reg <= {2'b01, {(dwc_pkg::RAD_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + pw_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            pw_reg <= pw_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[dwc_pkg::ROOT_W-1:0];

endmodule

FILE: rtl/core/dwc_div.sv
// Restoring divider for a fraction below one, one quotient bit per cycle.
module dwc_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dwc_pkg::DIV_W-1:0]   num,
    input  logic [dwc_pkg::DIV_W-1:0]   den,
    output logic                        done,
    output logic [dwc_pkg::QUO_W-1:0]   quo
);

    logic [dwc_pkg::DIV_W:0]   rem_reg;
    logic [dwc_pkg::DIV_W:0]   rem2;
    logic [dwc_pkg::DIV_W-1:0] den_reg;
    logic [dwc_pkg::QUO_W-1:0] quo_reg;
    logic [3:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic                      ge;

    assign rem2 = {rem_reg[dwc_pkg::DIV_W-1:0], 1'b0};
    assign ge   = rem2 >= {1'b0, den_reg};

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift, compare and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem2 - {1'b0, den_reg}) : rem2;
            quo_reg <= {quo_reg[dwc_pkg::QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: bench/tb_differential_uw_correlator_unit.sv
// Testbench of the differential unique-word correlator: stimulus, prediction and checking.
module tb_differential_uw_correlator_unit;

    localparam int UW_DEPTH  = 256;
    localparam int LAG_DEPTH = 8;
    localparam int DRAIN_CYC = 450;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [15:0] metric;
        logic        zero_energy;
    } corr_word_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic wr_index;
    logic [5:0] wr_data;

    dwc_in_if  samples();
    dwc_out_if results();

    differential_uw_correlator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .results  (results),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Predictor state
    int unsigned    sps_reg;
    int unsigned    uw_reg;
    dwc_pkg::cplx_t uw_smp [UW_DEPTH];
    dwc_pkg::cplx_t uw_tap [UW_DEPTH];
    int unsigned    uw_tmag [UW_DEPTH];
    dwc_pkg::cplx_t lag_buf [LAG_DEPTH];
    dwc_pkg::cplx_t diff_win [UW_DEPTH];
    int unsigned    diff_mag [UW_DEPTH];
    int unsigned    win_ptr;
    int unsigned    held;

    corr_word_t  pending_corr [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          recv_hold;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint signed round_sat(longint signed p);
        longint signed q;
        q = (p + 16384) >>> 15;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q;
    endfunction

    function automatic dwc_pkg::cplx_t mul_conj(dwc_pkg::cplx_t a, dwc_pkg::cplx_t b);
        dwc_pkg::cplx_t r;
        longint signed pr;
        longint signed pi;
        pr = longint'(a.re) * b.re + longint'(a.im) * b.im;
        pi = longint'(a.im) * b.re - longint'(a.re) * b.im;
        r.re = 16'(round_sat(pr));
        r.im = 16'(round_sat(pi));
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int unsigned cplx_mag(dwc_pkg::cplx_t a);
        longint unsigned s;
        s = longint'(longint'(a.re) * a.re) + longint'(longint'(a.im) * a.im);
        return 32'(int_sqrt(s));
    endfunction

    function automatic int unsigned lag_now();
        if (sps_reg < 1)
            return 1;
        if (sps_reg > LAG_DEPTH)
            return LAG_DEPTH;
        return sps_reg;
    endfunction

    function automatic int unsigned taps_now();
        int unsigned u;
        int unsigned l;
        u = (uw_reg < 2) ? 2 : uw_reg;
        l = (u - 1) * lag_now();
        return (l > UW_DEPTH) ? UW_DEPTH : l;
    endfunction

    function automatic logic [15:0] scale_metric(longint signed nre, longint signed nim,
                                                 longint unsigned den);
        longint unsigned ar;
        longint unsigned ai;
        longint unsigned m;
        longint unsigned q;
        ar = (nre < 0) ? longint'(-nre) : longint'(nre);
        ai = (nim < 0) ? longint'(-nim) : longint'(nim);
        while (ar >= 64'h8000_0000 || ai >= 64'h8000_0000 || den >= 64'h8000_0000)
        begin
            ar = ar >> 1;
            ai = ai >> 1;
            den = den >> 1;
        end
        if (den == 0)
            return 16'hFFFF;
        m = int_sqrt(ar * ar + ai * ai);
        q = (m << 16) / den;
        return (q > 65535) ? 16'hFFFF : 16'(q);
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < LAG_DEPTH; i++)
            lag_buf[i] = '0;
        for (int i = 0; i < UW_DEPTH; i++)
        begin
            diff_win[i] = '0;
            diff_mag[i] = 0;
        end
        win_ptr = 0;
        held = 0;
    endfunction

    // Advance the predictor by one accepted word
    function automatic void predict_corr(logic [1:0] act, logic [7:0] idx, dwc_pkg::cplx_t x);
        int unsigned s;
        int unsigned j;
        int unsigned len;
        int unsigned slot;
        bit          warm;
        dwc_pkg::cplx_t older;
        dwc_pkg::cplx_t d;
        longint signed   nre;
        longint signed   nim;
        longint unsigned den;
        corr_word_t  w;
        s = lag_now();
        if (act == dwc_pkg::ACT_LOAD)
        begin
            uw_smp[idx] = x;
            if (idx >= s)
            begin
                j = idx - s;
                uw_tap[j] = mul_conj(x, uw_smp[j]);
                uw_tmag[j] = cplx_mag(uw_tap[j]);
            end
        end
        else if (act == dwc_pkg::ACT_CLEAR)
            clear_history();
        else if (act == dwc_pkg::ACT_DATA)
        begin
            warm = (held >= s);
            older = lag_buf[s-1];
            for (int i = LAG_DEPTH - 1; i > 0; i--)
                lag_buf[i] = lag_buf[i-1];
            lag_buf[0] = x;
            if (held < LAG_DEPTH)
                held++;
            if (warm)
            begin
                d = mul_conj(x, older);
                diff_win[win_ptr] = d;
                diff_mag[win_ptr] = cplx_mag(d);
                win_ptr = (win_ptr + 1) % UW_DEPTH;
                len = taps_now();
                nre = 0;
                nim = 0;
                den = 0;
                for (int t = 0; t < len; t++)
                begin
                    slot = (win_ptr + 2 * UW_DEPTH - 1 - (len - 1 - t)) % UW_DEPTH;
                    nre += longint'(uw_tap[t].re) * diff_win[slot].re
                         - longint'(uw_tap[t].im) * diff_win[slot].im;
                    nim += longint'(uw_tap[t].re) * diff_win[slot].im
                         + longint'(uw_tap[t].im) * diff_win[slot].re;
                    den += longint'(uw_tmag[t]) * diff_mag[slot];
                end
                if (den == 0)
                begin
                    w.metric = '0;
                    w.zero_energy = 1'b1;
                end
                else
                begin
                    w.metric = scale_metric(nre, nim, den);
                    w.zero_energy = 1'b0;
                end
                pending_corr.push_back(w);
            end
        end
    endfunction

    // Receiver: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            results.ready = 1'b0;
            recv_hold--;
        end
        else
            results.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin
        corr_word_t w;
        if (rst_n && results.valid && results.ready)
        begin
            if (pending_corr.size() == 0)
            begin
                $display("%0t: unexpected result word metric=%0d zero_energy=%0b",
                         $time, results.metric, results.zero_energy);
                error_count++;
            end
            else
            begin
                w = pending_corr.pop_front();
                if (results.metric !== w.metric)
                begin
                    $display("%0t: metric expected %0d actual %0d",
                             $time, w.metric, results.metric);
                    error_count++;
                end
                if (results.zero_energy !== w.zero_energy)
                begin
                    $display("%0t: zero_energy expected %0b actual %0b",
                             $time, w.zero_energy, results.zero_energy);
                    error_count++;
                end
            end
        end
    end

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Send one word and advance the predictor once it is taken
    task automatic send_word(logic [1:0] act, logic [7:0] idx,
                             logic signed [15:0] si, logic signed [15:0] sq);
        dwc_pkg::cplx_t x;
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples.valid = 1'b0;
            @(negedge clk);
        end
        samples.valid = 1'b1;
        samples.action = act;
        samples.ref_index = idx;
        samples.sample_i = si;
        samples.sample_q = sq;
        do
            @(posedge clk);
        while (!samples.ready);
        x.re = si;
        x.im = sq;
        predict_corr(act, idx, x);
        @(negedge clk);
    endtask

    // Drop valid, drain results, and let trailing work finish
    task automatic wait_idle();
        samples.valid = 1'b0;
        while (pending_corr.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [5:0] val);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = val;
        @(negedge clk);
        wr_en = 1'b0;
        if (idx == dwc_pkg::REG_SPS)
            sps_reg = val & 6'hF;
        else
            uw_reg = val & 6'h3F;
    endtask

    // Set both registers when idle, then load every reference sample the taps need
    task automatic program_uw(logic [5:0] sps_val, logic [5:0] uw_val);
        int unsigned top;
        wait_idle();
        write_reg(dwc_pkg::REG_SPS, sps_val);
        write_reg(dwc_pkg::REG_UW, uw_val);
        top = taps_now() + lag_now() - 1;
        for (int k = 0; k <= top; k++)
            send_word(dwc_pkg::ACT_LOAD, 8'(k), pick_sample(), pick_sample());
    endtask

    // Mostly data words with random content, some clears, reloads and unused actions
    task automatic run_mix(int n);
        int unsigned r;
        int unsigned k;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 6)
                send_word(dwc_pkg::ACT_CLEAR, 8'($urandom), pick_sample(), pick_sample());
            else if (r < 14)
            begin
                k = $urandom_range(taps_now() + lag_now() - 1);
                send_word(dwc_pkg::ACT_LOAD, 8'(k), pick_sample(), pick_sample());
            end
            else if (r < 17)
                send_word(ACT_UNUSED, 8'($urandom), pick_sample(), pick_sample());
            else
                send_word(dwc_pkg::ACT_DATA, 8'($urandom), pick_sample(), pick_sample());
        end
    endtask

    // Extremes, every action, warm-up, clear and zero energy
    task automatic test_directed();
        program_uw(6'd1, 6'd2);
        send_word(dwc_pkg::ACT_DATA, 8'hFF, 16'sd0, 16'sd0);
        send_word(dwc_pkg::ACT_DATA, 8'h00, 16'sd0, 16'sd0);
        send_word(dwc_pkg::ACT_DATA, 8'h00, 16'sd0, 16'sd0);
        send_word(dwc_pkg::ACT_DATA, 8'h00, -16'sd32768, -16'sd32768);
        send_word(dwc_pkg::ACT_DATA, 8'h00, 16'sd32767, 16'sd32767);
        send_word(dwc_pkg::ACT_DATA, 8'h00, -16'sd32768, 16'sd32767);
        send_word(dwc_pkg::ACT_DATA, 8'h00, 16'sd32767, -16'sd32768);
        send_word(ACT_UNUSED, 8'hAA, 16'sd1234, -16'sd1);
        send_word(dwc_pkg::ACT_DATA, 8'h55, 16'sd1, 16'sd0);
        send_word(dwc_pkg::ACT_CLEAR, 8'h00, 16'sd0, 16'sd0);
        send_word(dwc_pkg::ACT_DATA, 8'h00, 16'sd100, -16'sd100);
        send_word(dwc_pkg::ACT_DATA, 8'h00, -16'sd32768, 16'sd0);
        send_word(dwc_pkg::ACT_LOAD, 8'd0, 16'sd32767, -16'sd32768);
        send_word(dwc_pkg::ACT_LOAD, 8'd1, -16'sd32768, 16'sd32767);
        send_word(dwc_pkg::ACT_DATA, 8'h00, 16'sd32767, 16'sd0);
        send_word(dwc_pkg::ACT_DATA, 8'h00, 16'sd0, -16'sd32768);
    endtask

    // Largest lag and a 248-tap window; a full reference sweep reaches index 255
    task automatic test_full_sweep();
        wait_idle();
        write_reg(dwc_pkg::REG_SPS, 6'd15);
        write_reg(dwc_pkg::REG_UW, 6'd32);
        for (int k = 0; k < UW_DEPTH; k++)
            send_word(dwc_pkg::ACT_LOAD, 8'(k), pick_sample(), pick_sample());
        send_word(dwc_pkg::ACT_LOAD, 8'd255, -16'sd32768, 16'sd32767);
        run_mix(40);
    endtask

    // Out-of-range register values: zero lag and short unique words act clamped
    task automatic test_clamped_regs();
        program_uw(6'd0, 6'd0);
        run_mix(25);
        program_uw(6'd8, 6'd1);
        run_mix(20);
        wait_idle();
        write_reg(dwc_pkg::REG_UW, 6'd63);
        write_reg(dwc_pkg::REG_SPS, 6'd3);
        send_word(dwc_pkg::ACT_CLEAR, 8'd0, 16'sd0, 16'sd0);
        send_word(dwc_pkg::ACT_LOAD, 8'd2, 16'sd5, 16'sd5);
    endtask

    task automatic test_random(int phases);
        for (int p = 0; p < phases; p++)
        begin
            if ($urandom_range(5) == 0)
                program_uw(6'($urandom_range(1, 8)), 6'($urandom_range(2, 32)));
            else
                program_uw(6'($urandom_range(1, 4)), 6'($urandom_range(2, 6)));
            run_mix($urandom_range(20, 45));
        end
    endtask

    // Hold the receiver off while data keeps coming, so the input stalls
    task automatic test_backpressure();
        program_uw(6'd2, 6'd4);
        recv_hold = 3000;
        for (int i = 0; i < 24; i++)
            send_word(dwc_pkg::ACT_DATA, 8'($urandom), pick_sample(), pick_sample());
    endtask

    initial
    begin
        error_count = 0;
        send_idle_pct = 25;
        recv_idle_pct = 73;
        recv_hold = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = 1'b0;
        wr_data = '0;
        samples.valid = 1'b0;
        samples.action = dwc_pkg::ACT_LOAD;
        samples.ref_index = '0;
        samples.sample_i = '0;
        samples.sample_q = '0;
        results.ready = 1'b0;
        sps_reg = 1;
        uw_reg = 2;
        for (int i = 0; i < UW_DEPTH; i++)
        begin
            uw_smp[i] = '0;
            uw_tap[i] = '0;
            uw_tmag[i] = 0;
        end
        clear_history();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_full_sweep();
        test_clamped_regs();
        test_random(4);
        send_idle_pct = 73;
        recv_idle_pct = 25;
        test_random(4);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(4);

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
